### rtl/dhtwm_pkg.sv
// ----------------------------------------------------------------------------
// dhtwm_pkg
// Shared types and constants of the hole-tolerant DNA window matcher.
// ----------------------------------------------------------------------------
package dhtwm_pkg;

	localparam int MAX_PATTERN   = 1024;
	localparam int ADDR_W        = $clog2(MAX_PATTERN);
	localparam int POSITION_BITS = 32;
	localparam int REG_W         = 11;
	localparam int CFG_IDX_W     = 2;
	localparam int MATCH_POS_W   = 32;
	localparam int PIDX_W        = 10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLE_WIDTH = 2'd2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_SEQ  = 1'b1;

	localparam logic DIR_FWD = 1'b0;
	localparam logic DIR_BWD = 1'b1;

	localparam logic [REG_W-1:0] PATTERN_LENGTH_RST = 11'd2;

	typedef struct packed {
		logic              kind;
		logic [1:0]        symbol;
		logic [PIDX_W-1:0] pattern_index;
		logic              final_symbol;
	} item_t;

	typedef struct packed {
		logic [MATCH_POS_W-1:0] match_position;
		logic                   direction;
		logic                   run_end;
	} result_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic emit_f;
		logic emit_b;
	} dp_cmd_t;

	typedef struct packed {
		logic check;
		logic last_issue;
		logic both_failed;
		logic fwd_ok;
		logic bwd_ok;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/dhtwm_dp.sv
// ----------------------------------------------------------------------------
// dhtwm_dp
// Datapath: configuration registers, pattern and window stores, position
// counter, forward and backward mismatch-run trackers, result register.
// ----------------------------------------------------------------------------
module dhtwm_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dhtwm_pkg::item_t                     item,
	input  dhtwm_pkg::dp_cmd_t                   cmd,
	output dhtwm_pkg::dp_status_t                status,
	input  logic                                 cfg_we,
	input  logic [dhtwm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dhtwm_pkg::REG_W-1:0]          cfg_data,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output dhtwm_pkg::result_t                   result
);

	typedef struct packed {
		logic [dhtwm_pkg::ADDR_W-1:0] run;
		logic [dhtwm_pkg::ADDR_W-1:0] runs;
		logic                         fail;
	} hole_t;

	function automatic hole_t hole_next(
		input logic                         mism,
		input hole_t                        cur,
		input logic [dhtwm_pkg::REG_W-1:0] max_cnt,
		input logic [dhtwm_pkg::REG_W-1:0] max_wid
	);
		hole_t nx;
		nx = cur;
		if (mism) begin
			nx.run = cur.run + 1'b1;
			if (cur.run == '0) begin
				nx.runs = cur.runs + 1'b1;
			end
			if (dhtwm_pkg::REG_W'(nx.run) > max_wid ||
			    dhtwm_pkg::REG_W'(nx.runs) > max_cnt) begin
				nx.fail = 1'b1;
			end
		end else begin
			nx.run = '0;
		end
		return nx;
	endfunction

	logic [dhtwm_pkg::REG_W-1:0]         pattern_length_q;
	logic [dhtwm_pkg::REG_W-1:0]         max_hole_count_q;
	logic [dhtwm_pkg::REG_W-1:0]         max_hole_width_q;
	logic [dhtwm_pkg::POSITION_BITS-1:0] symbols_seen_q;
	logic [dhtwm_pkg::POSITION_BITS-1:0] start_q;
	logic [dhtwm_pkg::ADDR_W-1:0]        k_q;
	hole_t                               hole_f_q;
	hole_t                               hole_b_q;
	logic                                issue_s1;
	logic [1:0]                          pat_f_s1;
	logic [1:0]                          pat_b_s1;
	logic [1:0]                          win_s1;
	logic                                result_valid_q;
	dhtwm_pkg::result_t                  result_q;

	logic [1:0] pattern_mem [dhtwm_pkg::MAX_PATTERN];
	logic [1:0] window_mem  [dhtwm_pkg::MAX_PATTERN];

	logic [dhtwm_pkg::REG_W-1:0]         p_eff;
	logic [dhtwm_pkg::ADDR_W-1:0]        p_m2;
	logic                                seq_accept;
	logic                                load_accept;

	// effective pattern length, saturated into 2 .. MAX_PATTERN
	always_comb begin
		p_eff = pattern_length_q;
		if (pattern_length_q < dhtwm_pkg::PATTERN_LENGTH_RST) begin
			p_eff = dhtwm_pkg::PATTERN_LENGTH_RST;
		end else if (pattern_length_q > dhtwm_pkg::REG_W'(dhtwm_pkg::MAX_PATTERN)) begin
			p_eff = dhtwm_pkg::REG_W'(dhtwm_pkg::MAX_PATTERN);
		end
	end

	// P-2: the window start offset and also the last compare index
	assign p_m2 = dhtwm_pkg::ADDR_W'(p_eff - dhtwm_pkg::PATTERN_LENGTH_RST);

	assign seq_accept  = cmd.accept && (item.kind == dhtwm_pkg::KIND_SEQ);
	assign load_accept = cmd.accept && (item.kind == dhtwm_pkg::KIND_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= dhtwm_pkg::PATTERN_LENGTH_RST;
			max_hole_count_q <= '0;
			max_hole_width_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dhtwm_pkg::CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data;
				dhtwm_pkg::CFG_MAX_HOLE_COUNT: max_hole_count_q <= cfg_data;
				dhtwm_pkg::CFG_MAX_HOLE_WIDTH: max_hole_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbols_seen_q <= '0;
		end else if (seq_accept) begin
			symbols_seen_q <= item.final_symbol ? '0 : symbols_seen_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_accept) begin
			pattern_mem[item.pattern_index] <= item.symbol;
		end
		pat_f_s1 <= pattern_mem[k_q];
		pat_b_s1 <= pattern_mem[p_m2 - k_q];
	end

	always_ff @(posedge clk) begin
		if (seq_accept) begin
			window_mem[symbols_seen_q[dhtwm_pkg::ADDR_W-1:0]] <= item.symbol;
		end
		win_s1 <= window_mem[start_q[dhtwm_pkg::ADDR_W-1:0] + k_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			start_q <= symbols_seen_q - dhtwm_pkg::POSITION_BITS'(p_m2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			issue_s1 <= 1'b0;
			hole_f_q <= '0;
			hole_b_q <= '0;
		end else begin
			issue_s1 <= cmd.step;
			if (cmd.accept) begin
				k_q <= '0;
			end else if (cmd.step) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.accept) begin
				hole_f_q <= '0;
				hole_b_q <= '0;
			end else if (issue_s1) begin
				hole_f_q <= hole_next(win_s1 != pat_f_s1, hole_f_q,
				                      max_hole_count_q, max_hole_width_q);
				hole_b_q <= hole_next(win_s1 != pat_b_s1, hole_b_q,
				                      max_hole_count_q, max_hole_width_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit_f || cmd.emit_b) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_f) begin
			result_q.match_position <= dhtwm_pkg::MATCH_POS_W'(start_q);
			result_q.direction      <= dhtwm_pkg::DIR_FWD;
			result_q.run_end        <= hole_b_q.fail;
		end else if (cmd.emit_b) begin
			result_q.match_position <= dhtwm_pkg::MATCH_POS_W'(start_q);
			result_q.direction      <= dhtwm_pkg::DIR_BWD;
			result_q.run_end        <= 1'b1;
		end
	end

	assign status.check       = (item.kind == dhtwm_pkg::KIND_SEQ) && !item.final_symbol &&
	                            (symbols_seen_q >= dhtwm_pkg::POSITION_BITS'(p_m2));
	assign status.last_issue  = (k_q == p_m2);
	assign status.both_failed = hole_f_q.fail && hole_b_q.fail;
	assign status.fwd_ok      = !hole_f_q.fail;
	assign status.bwd_ok      = !hole_b_q.fail;
	assign status.out_free    = !result_valid_q || !result_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### rtl/dhtwm_ctrl.sv
// ----------------------------------------------------------------------------
// dhtwm_ctrl
// Controller: takes items, walks the window one symbol pair per cycle and
// hands the forward and backward results to the output register.
// ----------------------------------------------------------------------------
module dhtwm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  dhtwm_pkg::dp_status_t status,
	output dhtwm_pkg::dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_WALK   = 5'b00010,
		S_DRAIN  = 5'b00100,
		S_EMIT_F = 5'b01000,
		S_EMIT_B = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.accept = 1'b1;
					if (status.check) begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				// stop early once both directions have already failed
				if (status.both_failed) begin
					state_d = S_EMIT_F;
				end else begin
					cmd.step = 1'b1;
					if (status.last_issue) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				state_d = S_EMIT_F;
			end
			S_EMIT_F: begin
				if (!status.fwd_ok) begin
					state_d = S_EMIT_B;
				end else if (status.out_free) begin
					cmd.emit_f = 1'b1;
					state_d    = S_EMIT_B;
				end
			end
			S_EMIT_B: begin
				if (!status.bwd_ok) begin
					state_d = S_IDLE;
				end else if (status.out_free) begin
					cmd.emit_b = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/dna_hole_tolerant_window_match.sv
// ----------------------------------------------------------------------------
// dna_hole_tolerant_window_match
// Approximate DNA pattern match that tolerates runs of mismatches.
// ----------------------------------------------------------------------------
// Load pattern symbols with kind 0, then stream sequence symbols with kind 1.
// A load, or a sequence symbol that completes no window, leaves the block idle. A
// symbol that completes a window of P-1 symbols starts a walk through the
// window and the pattern prefix, forward and reversed side by side, one symbol
// pair per cycle out of the two stores; the item then goes through the accept,
// the walk, a drain of the store read and the hand-off of the forward, then the
// backward result; the walk ends early when both directions fail, and the item
// may wait while the result register stalls. Results leave through a register,
// so the next item is taken while the last result still waits. Configuration
// is always ready and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module dna_hole_tolerant_window_match (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  dhtwm_pkg::item_t                  item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output dhtwm_pkg::result_t                result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dhtwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dhtwm_pkg::REG_W-1:0]       cfg_data
);

	dhtwm_pkg::dp_cmd_t    cmd;
	dhtwm_pkg::dp_status_t status;
	logic                  cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	dhtwm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	dhtwm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
